>>> hw/rtl/itoa_pkg.sv
// Shared types, codes and character helpers for the integer-to-ASCII formatter.
`timescale 1ns / 1ps

package itoa_pkg;

	localparam int OP_W       = 3;
	localparam int VALUE_W    = 64;
	localparam int DEC_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = BCD_DIGITS * 4;
	localparam int NIBBLES    = VALUE_W / 4;
	localparam int IDX_W      = $clog2(NIBBLES);
	localparam int STEP_W     = $clog2(DEC_W);
	localparam int PFX_CNT_W  = 3;
	localparam int CHAR_W     = 8;

	// Format operation codes
	localparam logic [OP_W-1:0] OP_UDEC      = 3'd0;
	localparam logic [OP_W-1:0] OP_SDEC      = 3'd1;
	localparam logic [OP_W-1:0] OP_HEX_LOWER = 3'd2;
	localparam logic [OP_W-1:0] OP_HEX_UPPER = 3'd3;
	localparam logic [OP_W-1:0] OP_PTR       = 3'd4;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX,
		PFX_NIL
	} pfx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SCAN,
		S_PREFIX,
		S_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic scan;
		logic emit_pfx;
		logic emit_dig;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic conv_done;
		logic pfx_none;
		logic pfx_nil;
		logic pfx_last;
		logic dig_last;
		logic out_free;
	} sts_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] base;
		begin
			base = upper ? 8'h41 : 8'h61;
			if (d < 4'd10)
				hex_char = 8'h30 + {4'b0000, d};
			else
				hex_char = base + {4'b0000, d} - 8'd10;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] pfx_char(input pfx_t kind,
			input logic [PFX_CNT_W-1:0] k);
		begin
			pfx_char = 8'h3f;
			case (kind)
				PFX_MINUS: pfx_char = 8'h2d;
				PFX_HEX:   pfx_char = (k == 3'd0) ? 8'h30 : 8'h78;
				PFX_NIL: begin
					case (k)
						3'd0:    pfx_char = 8'h28;
						3'd1:    pfx_char = 8'h6e;
						3'd2:    pfx_char = 8'h69;
						3'd3:    pfx_char = 8'h6c;
						default: pfx_char = 8'h29;
					endcase
				end
				default:   pfx_char = 8'h3f;
			endcase
		end
	endfunction

	function automatic logic pfx_is_last(input pfx_t kind, input logic [PFX_CNT_W-1:0] k);
		begin
			case (kind)
				PFX_MINUS: pfx_is_last = (k == 3'd0);
				PFX_HEX:   pfx_is_last = (k == 3'd1);
				PFX_NIL:   pfx_is_last = (k == 3'd4);
				default:   pfx_is_last = 1'b1;
			endcase
		end
	endfunction

endpackage

>>> hw/rtl/itoa_if.sv
// Valid/ready channel interfaces for formatter requests and characters.
`timescale 1ns / 1ps

interface itoa_in_if;
	logic                         valid;
	logic                         ready;
	logic [itoa_pkg::OP_W-1:0]    operation;
	logic [itoa_pkg::VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface itoa_out_if;
	logic                        valid;
	logic                        ready;
	logic [itoa_pkg::CHAR_W-1:0] character;
	logic                        last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

>>> hw/rtl/itoa_dp.sv
// Datapath: operand capture, shift-add-3 decimal conversion, digit scan and output register.
`timescale 1ns / 1ps

module itoa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [itoa_pkg::OP_W-1:0]      operation,
	input  logic [itoa_pkg::VALUE_W-1:0]   value,
	input  itoa_pkg::cmd_t                 cmd,
	output itoa_pkg::sts_t                 sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [itoa_pkg::CHAR_W-1:0]    character,
	output logic                           last
);

	logic [itoa_pkg::VALUE_W-1:0]   val_q;
	logic [itoa_pkg::BCD_W-1:0]     bcd_q;
	logic [itoa_pkg::STEP_W-1:0]    step_q;
	logic [itoa_pkg::IDX_W-1:0]     idx_q;
	logic [itoa_pkg::PFX_CNT_W-1:0] pfx_cnt_q;
	itoa_pkg::pfx_t                 pfx_q;
	logic                           dec_q;
	logic                           upper_q;
	logic                           drop_q;
	logic                           out_valid_q;
	logic [itoa_pkg::CHAR_W-1:0]    char_q;
	logic                           last_q;

	logic [itoa_pkg::DEC_W-1:0]     low;
	logic [itoa_pkg::DEC_W-1:0]     mag;
	logic [itoa_pkg::BCD_W-1:0]     bcd_adj;
	logic [itoa_pkg::BCD_W-1:0]     bcd_next;
	logic [itoa_pkg::IDX_W-1:0]     top;
	logic [3:0]                     nib;
	logic                           out_free;

	assign low = value[itoa_pkg::DEC_W-1:0];
	assign mag = low[itoa_pkg::DEC_W-1] ? (itoa_pkg::DEC_W'(0) - low) : low;

	// Add three to every BCD digit of five or more, then shift in the next binary bit
	always_comb begin
		for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5)
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			else
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
		end
		bcd_next = {bcd_adj[itoa_pkg::BCD_W-2:0], val_q[itoa_pkg::DEC_W-1]};
	end

	// Highest nonzero nibble, zero when the word is zero
	always_comb begin
		top = '0;
		for (int i = 0; i < itoa_pkg::NIBBLES; i++) begin
			if (val_q[i*4 +: 4] != 4'd0)
				top = itoa_pkg::IDX_W'(i);
		end
	end

	assign nib      = val_q[{idx_q, 2'b00} +: 4];
	assign out_free = !out_valid_q || out_ready;

	assign sts.drop      = drop_q;
	assign sts.conv_done = !dec_q || (step_q == itoa_pkg::STEP_W'(itoa_pkg::DEC_W - 1));
	assign sts.pfx_none  = (pfx_q == itoa_pkg::PFX_NONE);
	assign sts.pfx_nil   = (pfx_q == itoa_pkg::PFX_NIL);
	assign sts.pfx_last  = itoa_pkg::pfx_is_last(pfx_q, pfx_cnt_q);
	assign sts.dig_last  = (idx_q == '0);
	assign sts.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			step_q    <= '0;
			pfx_cnt_q <= '0;
			bcd_q     <= '0;
			drop_q    <= (operation > itoa_pkg::OP_PTR);
			dec_q     <= (operation == itoa_pkg::OP_UDEC) || (operation == itoa_pkg::OP_SDEC);
			upper_q   <= (operation == itoa_pkg::OP_HEX_UPPER);
			case (operation)
				itoa_pkg::OP_UDEC: begin
					val_q <= {{(itoa_pkg::VALUE_W-itoa_pkg::DEC_W){1'b0}}, low};
					pfx_q <= itoa_pkg::PFX_NONE;
				end
				itoa_pkg::OP_SDEC: begin
					val_q <= {{(itoa_pkg::VALUE_W-itoa_pkg::DEC_W){1'b0}}, mag};
					pfx_q <= low[itoa_pkg::DEC_W-1] ? itoa_pkg::PFX_MINUS : itoa_pkg::PFX_NONE;
				end
				itoa_pkg::OP_PTR: begin
					val_q <= value;
					pfx_q <= (value != '0) ? itoa_pkg::PFX_HEX : itoa_pkg::PFX_NIL;
				end
				default: begin
					val_q <= value;
					pfx_q <= itoa_pkg::PFX_NONE;
				end
			endcase
		end
		if (cmd.conv_step && dec_q) begin
			step_q <= step_q + 1'b1;
			bcd_q  <= bcd_next;
			// On the final step the BCD digits replace the operand
			if (step_q == itoa_pkg::STEP_W'(itoa_pkg::DEC_W - 1))
				val_q <= {{(itoa_pkg::VALUE_W-itoa_pkg::BCD_W){1'b0}}, bcd_next};
			else
				val_q <= {val_q[itoa_pkg::VALUE_W-1:itoa_pkg::DEC_W],
					val_q[itoa_pkg::DEC_W-2:0], 1'b0};
		end
		if (cmd.scan)
			idx_q <= top;
		if (cmd.emit_pfx) begin
			pfx_cnt_q <= pfx_cnt_q + 1'b1;
			char_q    <= itoa_pkg::pfx_char(pfx_q, pfx_cnt_q);
			last_q    <= (pfx_q == itoa_pkg::PFX_NIL) && itoa_pkg::pfx_is_last(pfx_q, pfx_cnt_q);
		end
		if (cmd.emit_dig) begin
			idx_q  <= idx_q - 1'b1;
			char_q <= itoa_pkg::hex_char(nib, upper_q);
			last_q <= (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pfx || cmd.emit_dig) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/itoa_ctrl.sv
// Controller state machine sequencing load, conversion, scan and character emission.
`timescale 1ns / 1ps

module itoa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output itoa_pkg::cmd_t cmd,
	input  itoa_pkg::sts_t sts
);

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			itoa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = itoa_pkg::S_CONV;
				end
			end
			itoa_pkg::S_CONV: begin
				// Drop items with an unused operation code
				if (sts.drop) begin
					state_d = itoa_pkg::S_IDLE;
				end else begin
					cmd.conv_step = 1'b1;
					if (sts.conv_done)
						state_d = itoa_pkg::S_SCAN;
				end
			end
			itoa_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = sts.pfx_none ? itoa_pkg::S_DIGITS : itoa_pkg::S_PREFIX;
			end
			itoa_pkg::S_PREFIX: begin
				if (sts.out_free) begin
					cmd.emit_pfx = 1'b1;
					if (sts.pfx_last)
						state_d = sts.pfx_nil ? itoa_pkg::S_IDLE : itoa_pkg::S_DIGITS;
				end
			end
			itoa_pkg::S_DIGITS: begin
				if (sts.out_free) begin
					cmd.emit_dig = 1'b1;
					if (sts.dig_last)
						state_d = itoa_pkg::S_IDLE;
				end
			end
			default: state_d = itoa_pkg::S_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.conv_step, cmd.scan, cmd.emit_pfx, cmd.emit_dig}))
		else $error("more than one datapath command at once");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pfx || cmd.emit_dig) |-> sts.out_free)
		else $error("beat emitted over an occupied output register");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_dig && sts.dig_last) |=> (state_q == itoa_pkg::S_IDLE))
		else $error("final digit did not end the item");

	a_scan_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |=> (state_q == itoa_pkg::S_PREFIX || state_q == itoa_pkg::S_DIGITS))
		else $error("scan not followed by emission");
`endif

endmodule

>>> hw/rtl/integer_to_ascii_formatter_top.sv
// Top level of the integer-to-ASCII formatter.
`timescale 1ns / 1ps

// Formats one 64-bit value per request beat as ASCII text, one character per output
// beat, most significant first, with last set on the final character. Operations:
// unsigned decimal and signed decimal of the low 32 bits, hex lower or upper case
// without leading zeros, and pointer ("0x" plus lower hex, or "(nil)" for zero).
// Unused operation codes are consumed with no output. One item is handled at a time:
// a decimal item is accepted, run through the shift-add-3 loop over its 32 bits,
// scanned for its top digit and then sent one character per cycle (up to 11) while
// the output is free; a hex or pointer item skips the conversion steps and is sent
// the same way (up to 18). A stalled output simply holds the sequence.
module integer_to_ascii_formatter_top (
	input logic        clk,
	input logic        arst_n,
	itoa_in_if.sink    in_item,
	itoa_out_if.source out_char
);

	itoa_pkg::cmd_t cmd;
	itoa_pkg::sts_t sts;

	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_ready (in_item.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	itoa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.operation (in_item.operation),
		.value     (in_item.value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_char.valid),
		.out_ready (out_char.ready),
		.character (out_char.character),
		.last      (out_char.last)
	);

endmodule

>>> tb/integer_to_ascii_formatter_top_tb.sv
// Testbench for the integer-to-ASCII formatter: predicts every character and checks it.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_tb;

	// Codes 5 to 7 carry no format; the block drops them without output
	localparam logic [itoa_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [itoa_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [itoa_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

	localparam logic [39:0] NIL_TEXT   = "(nil)";
	localparam int          TAIL_WAIT  = 80;
	localparam int          MAX_NOTES  = 30;

	typedef struct packed {
		logic [itoa_pkg::CHAR_W-1:0] character;
		logic                        last;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	itoa_in_if  in_item();
	itoa_out_if out_char();

	integer_to_ascii_formatter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_char (out_char)
	);

	char_beat_t expected_text[$];
	int         mismatches   = 0;
	int         requests     = 0;
	int         dropped_ops  = 0;
	int         chars_seen   = 0;
	int         hold_off     = 0;
	bit         steady_rx    = 1'b0;
	bit         steady_tx    = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Build the character stream for one request and queue it
	function automatic void predict_text(input logic [itoa_pkg::OP_W-1:0] op,
			input logic [itoa_pkg::VALUE_W-1:0] value);
		logic [itoa_pkg::CHAR_W-1:0]  txt[$];
		logic [itoa_pkg::CHAR_W-1:0]  digs[$];
		logic [itoa_pkg::DEC_W-1:0]   mag;
		logic [itoa_pkg::VALUE_W-1:0] v;
		logic [3:0]                   d;
		logic                         upper;
		char_beat_t                   b;
		mag   = value[itoa_pkg::DEC_W-1:0];
		v     = value;
		upper = (op == itoa_pkg::OP_HEX_UPPER);
		if (op == itoa_pkg::OP_UDEC || op == itoa_pkg::OP_SDEC) begin
			if (op == itoa_pkg::OP_SDEC && mag[itoa_pkg::DEC_W-1]) begin
				txt.push_back("-");
				mag = 32'd0 - mag;
			end
			do begin
				digs.push_front(8'(32'h30 + mag % 10));
				mag = mag / 10;
			end while (mag != 0);
		end else if (op == itoa_pkg::OP_HEX_LOWER || op == itoa_pkg::OP_HEX_UPPER ||
				(op == itoa_pkg::OP_PTR && value != 0)) begin
			if (op == itoa_pkg::OP_PTR) begin
				txt.push_back("0");
				txt.push_back("x");
			end
			do begin
				d = v[3:0];
				if (d < 4'd10)
					digs.push_front(8'h30 + {4'b0, d});
				else
					digs.push_front((upper ? 8'h41 : 8'h61) + {4'b0, d} - 8'd10);
				v = v >> 4;
			end while (v != 0);
		end else if (op == itoa_pkg::OP_PTR) begin
			for (int i = 4; i >= 0; i--)
				txt.push_back(NIL_TEXT[i*8 +: 8]);
		end else begin
			dropped_ops++;
			return;
		end
		foreach (digs[i])
			txt.push_back(digs[i]);
		foreach (txt[i]) begin
			b.character = txt[i];
			b.last      = (i == txt.size() - 1);
			expected_text.push_back(b);
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_NOTES)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Offer one request, hold it until accepted, then idle for a random gap, which may be none
	task automatic send_request(input logic [itoa_pkg::OP_W-1:0] op,
			input logic [itoa_pkg::VALUE_W-1:0] value);
		int gap;
		in_item.valid     = 1'b1;
		in_item.operation = op;
		in_item.value     = value;
		do
			@(posedge clk);
		while (!in_item.ready);
		predict_text(op, value);
		requests++;
		@(negedge clk);
		gap = steady_tx ? 0 : gap_len();
		if (gap > 0) begin
			in_item.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic idle_input();
		in_item.valid = 1'b0;
	endtask

	task automatic wait_drained();
		idle_input();
		while (expected_text.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [itoa_pkg::VALUE_W-1:0] random_value();
		logic [itoa_pkg::VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: v = 64'($urandom_range(0, 20));
			1: v = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
			2: v = 64'd1 << $urandom_range(0, 63);
			3: v = {$urandom, 32'h8000_0000 + $urandom_range(0, 15)};
			4: v = ~(64'($urandom_range(0, 255)));
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [itoa_pkg::OP_W-1:0] random_op();
		if ($urandom_range(0, 99) < 8)
			return itoa_pkg::OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
		return itoa_pkg::OP_W'($urandom_range(itoa_pkg::OP_UDEC, itoa_pkg::OP_PTR));
	endfunction

	task automatic test_corner_values();
		send_request(itoa_pkg::OP_UDEC, 64'd0);
		send_request(itoa_pkg::OP_SDEC, 64'd0);
		send_request(itoa_pkg::OP_HEX_LOWER, 64'd0);
		send_request(itoa_pkg::OP_HEX_UPPER, 64'd0);
		send_request(itoa_pkg::OP_PTR, 64'd0);
		send_request(itoa_pkg::OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(itoa_pkg::OP_UDEC, 64'hDEAD_BEEF_0000_0007);
		send_request(itoa_pkg::OP_SDEC, 64'h0000_0000_8000_0000);
		send_request(itoa_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(itoa_pkg::OP_SDEC, 64'h1234_5678_7FFF_FFFF);
		send_request(itoa_pkg::OP_SDEC, 64'h0000_0000_0000_0001);
		send_request(itoa_pkg::OP_HEX_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(itoa_pkg::OP_HEX_LOWER, 64'h0123_4567_89AB_CDEF);
		send_request(itoa_pkg::OP_HEX_UPPER, 64'hFEDC_BA98_7654_3210);
		send_request(itoa_pkg::OP_HEX_UPPER, 64'h8000_0000_0000_0000);
		send_request(itoa_pkg::OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(itoa_pkg::OP_PTR, 64'd1);
		send_request(itoa_pkg::OP_PTR, 64'h0000_7FFC_ABCD_0010);
		send_request(OP_SPARE_A, 64'h0000_0000_0000_0005);
		send_request(OP_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_SPARE_C, 64'd0);
		send_request(itoa_pkg::OP_UDEC, 64'd4294967295);
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			// alternate stretches with and without idle cycles
			steady_tx = (i / 15) % 3 == 1;
			steady_rx = (i / 20) % 3 == 2;
			send_request(random_op(), random_value());
		end
		steady_tx = 1'b0;
		steady_rx = 1'b0;
	endtask

	// Stall the output long enough that the input backs up
	task automatic test_output_hold();
		@(negedge clk);
		hold_off = 300;
		steady_tx = 1'b1;
		for (int i = 0; i < 6; i++)
			send_request(itoa_pkg::OP_W'($urandom_range(itoa_pkg::OP_UDEC, itoa_pkg::OP_PTR)),
				random_value());
		steady_tx = 1'b0;
	endtask

	task automatic test_drain_and_resume();
		send_request(itoa_pkg::OP_PTR, random_value());
		send_request(itoa_pkg::OP_SDEC, 64'h0000_0000_8000_0000);
		wait_drained();
		send_request(itoa_pkg::OP_HEX_UPPER, random_value());
		send_request(itoa_pkg::OP_UDEC, random_value());
	endtask

	// Output side: random stalls, plus a counted hold when asked
	initial begin
		int stall;
		stall = 0;
		out_char.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_char.ready = 1'b0;
				hold_off--;
			end else if (stall > 0) begin
				out_char.ready = 1'b0;
				stall--;
			end else begin
				out_char.ready = 1'b1;
				if (!steady_rx && $urandom_range(0, 3) == 0)
					stall = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && out_char.valid && out_char.ready) begin
			chars_seen++;
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
					out_char.character, out_char.last));
			end else begin
				want = expected_text.pop_front();
				if (out_char.character !== want.character)
					report_mismatch($sformatf("character got 8'h%02h want 8'h%02h",
						out_char.character, want.character));
				if (out_char.last !== want.last)
					report_mismatch($sformatf("last got %0b want %0b on 8'h%02h",
						out_char.last, want.last, want.character));
			end
		end
	end

	initial begin
		#1_000_000;
		$display("integer_to_ascii_formatter_top: mismatch");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		in_item.valid     = 1'b0;
		in_item.operation = itoa_pkg::OP_UDEC;
		in_item.value     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_values();
		test_random_traffic(60);
		test_output_hold();
		test_drain_and_resume();
		test_random_traffic(20);

		wait_drained();
		repeat (TAIL_WAIT) @(negedge clk);

		$display("Ran %0d requests (%0d with unused op codes), %0d characters compared,",
			requests, dropped_ops, chars_seen);
		$display("under random gaps on both sides, a long output hold and a full drain pause.");
		if (mismatches == 0)
			$display("integer_to_ascii_formatter_top: match");
		else
			$display("integer_to_ascii_formatter_top: mismatch");
		$finish;
	end

endmodule

>>> integer_to_ascii_formatter_top.f
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_if.sv
hw/rtl/itoa_dp.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/integer_to_ascii_formatter_top.sv
tb/integer_to_ascii_formatter_top_tb.sv
